>>> hdl/rsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants for the relative signal difference block.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int PIXEL_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 12;
    localparam int SAMPLE_W       = 16;
    localparam int DATA_W         = 32;

    localparam logic [DATA_W-1:0] S32_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

    localparam logic [DATA_W-1:0] TRACK_LOW_RST  = 32'd0;
    localparam logic [DATA_W-1:0] TRACK_HIGH_RST = 32'd12288;

    typedef enum logic {
        REG_TRACK_LOW  = 1'b0,
        REG_TRACK_HIGH = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SAT,
        ST_TRACK,
        ST_OUT
    } back_state_t;

    // classified pixel handed from the front to the back
    typedef struct packed {
        logic [SAMPLE_W-1:0] mag;
        logic [SAMPLE_W-1:0] base;
        logic                neg;
        logic                inval;
        logic                last;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] track_low;
        logic signed [DATA_W-1:0] track_high;
    } cfg_t;

endpackage

>>> hdl/rsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_front
// Accepts pixel pairs, masks them to the pixel width and classifies them.
// ----------------------------------------------------------------------------
module rsd_front #(
    parameter int PIXEL_BITS = rsd_pkg::PIXEL_BITS_DEF
) (
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [2*rsd_pkg::SAMPLE_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tlast,
    input  logic                          q_full,
    output logic                          q_push,
    output rsd_pkg::item_t                q_item
);

    localparam int PW = (PIXEL_BITS < rsd_pkg::SAMPLE_W) ? PIXEL_BITS : rsd_pkg::SAMPLE_W;
    localparam logic [rsd_pkg::SAMPLE_W-1:0] MASK =
        {rsd_pkg::SAMPLE_W{1'b1}} >> (rsd_pkg::SAMPLE_W - PW);

    logic [rsd_pkg::SAMPLE_W-1:0] sig;
    logic [rsd_pkg::SAMPLE_W-1:0] base;

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb begin
        sig          = s_axis_tdata[rsd_pkg::SAMPLE_W-1:0] & MASK;
        base         = s_axis_tdata[2*rsd_pkg::SAMPLE_W-1:rsd_pkg::SAMPLE_W] & MASK;
        q_item.base  = base;
        q_item.neg   = sig < base;
        q_item.mag   = (sig < base) ? (base - sig) : (sig - base);
        q_item.inval = (base == '0);
        q_item.last  = s_axis_tlast;
    end

endmodule

>>> hdl/rsd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_fifo
// Two-entry queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module rsd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rsd_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output rsd_pkg::item_t pop_item,
    output logic           empty
);

    rsd_pkg::item_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_item = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hdl/rsd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_div
// Restoring divider, one quotient bit per cycle, giving the rounded ratio
// (2*mag*2^F + base) / (2*base).
// ----------------------------------------------------------------------------
module rsd_div #(
    parameter int PIXEL_BITS = rsd_pkg::PIXEL_BITS_DEF,
    parameter int FRAC_BITS  = rsd_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [rsd_pkg::SAMPLE_W-1:0] mag,
    input  logic [rsd_pkg::SAMPLE_W-1:0] base,
    output logic                         done,
    output logic [rsd_pkg::DATA_W+31:0]  quotient
);

    localparam int PW = (PIXEL_BITS < rsd_pkg::SAMPLE_W) ? PIXEL_BITS : rsd_pkg::SAMPLE_W;
    localparam int NW = PW + FRAC_BITS + 2;
    localparam int DW = PW + 1;
    localparam int RW = PW + 2;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] dvd_reg, dvd_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] rem_shift;
    logic          qbit;

    assign done     = (cnt_reg == CW'(1));
    assign quotient = (rsd_pkg::DATA_W + 32)'(dvd_reg);

    always_comb begin
        rem_shift = {rem_reg[RW-2:0], dvd_reg[NW-1]};
        qbit      = (rem_shift >= RW'(dsr_reg));
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            dvd_next = NW'({mag[PW-1:0], {FRAC_BITS{1'b0}}, 1'b0}) + NW'(base[PW-1:0]);
            rem_next = '0;
            dsr_next = {base[PW-1:0], 1'b0};
            cnt_next = CW'(NW);
        end else if (cnt_reg != '0) begin
            // quotient bits shift in where dividend bits leave
            dvd_next = {dvd_reg[NW-2:0], qbit};
            rem_next = qbit ? (rem_shift - RW'(dsr_reg)) : rem_shift;
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

>>> hdl/rsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_back
// Takes classified pixels from the queue, divides, saturates, tracks the
// window min/max and drives the result register.
// ----------------------------------------------------------------------------
module rsd_back #(
    parameter int PIXEL_BITS = rsd_pkg::PIXEL_BITS_DEF,
    parameter int FRAC_BITS  = rsd_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rsd_pkg::cfg_t                 cfg,
    input  logic                          q_empty,
    input  rsd_pkg::item_t                q_item,
    output logic                          q_pop,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [3*rsd_pkg::DATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                    m_axis_tuser,
    output logic                          m_axis_tlast
);

    localparam int DW = rsd_pkg::DATA_W;
    localparam logic [DW+1:0] TWO_FIX = (DW + 2)'(2) << FRAC_BITS;

    rsd_pkg::back_state_t state_reg, state_next;
    rsd_pkg::item_t       cur_reg, cur_next;

    logic signed [DW-1:0] c_reg, c_next;
    logic                 hit_reg, hit_next;
    logic signed [DW-1:0] min_reg, min_next;
    logic signed [DW-1:0] max_reg, max_next;
    logic                 any_reg, any_next;

    logic                 mvalid_reg, mvalid_next;
    logic [DW-1:0]        contrast_reg, contrast_next;
    logic [DW-1:0]        center_reg, center_next;
    logic [DW-1:0]        width_reg, width_next;
    logic                 inval_reg, inval_next;
    logic                 wvalid_reg, wvalid_next;
    logic                 done_reg, done_next;

    logic                 div_start;
    logic                 div_done;
    logic [DW+31:0]       quo;
    logic [DW-1:0]        c_sat;
    logic signed [DW:0]   sum;
    logic signed [DW+1:0] width_full;
    logic                 out_free;

    rsd_div #(
        .PIXEL_BITS (PIXEL_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .mag      (q_item.mag),
        .base     (q_item.base),
        .done     (div_done),
        .quotient (quo)
    );

    assign out_free      = !mvalid_reg || m_axis_tready;
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = {width_reg, center_reg, contrast_reg};
    assign m_axis_tuser  = {wvalid_reg, inval_reg};
    assign m_axis_tlast  = done_reg;

    always_comb begin
        // saturate the magnitude, then apply the sign
        if (cur_reg.inval) begin
            c_sat = '0;
        end else if (cur_reg.neg) begin
            c_sat = (quo >= (DW + 32)'(rsd_pkg::S32_MIN)) ? rsd_pkg::S32_MIN : -quo[DW-1:0];
        end else begin
            c_sat = (quo > (DW + 32)'(rsd_pkg::S32_MAX)) ? rsd_pkg::S32_MAX : quo[DW-1:0];
        end

        sum        = (DW + 1)'(min_reg) + (DW + 1)'(max_reg);
        width_full = (DW + 2)'(max_reg) - (DW + 2)'(min_reg) + $signed(TWO_FIX);

        state_next    = state_reg;
        cur_next      = cur_reg;
        c_next        = c_reg;
        hit_next      = hit_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        any_next      = any_reg;
        mvalid_next   = mvalid_reg && !m_axis_tready;
        contrast_next = contrast_reg;
        center_next   = center_reg;
        width_next    = width_reg;
        inval_next    = inval_reg;
        wvalid_next   = wvalid_reg;
        done_next     = done_reg;
        q_pop         = 1'b0;
        div_start     = 1'b0;

        unique case (state_reg)
            rsd_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    if (q_item.inval) begin
                        state_next = rsd_pkg::ST_SAT;
                    end else begin
                        div_start  = 1'b1;
                        state_next = rsd_pkg::ST_DIV;
                    end
                end
            end
            rsd_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = rsd_pkg::ST_SAT;
                end
            end
            rsd_pkg::ST_SAT: begin
                c_next     = $signed(c_sat);
                hit_next   = !cur_reg.inval && ($signed(c_sat) >= cfg.track_low)
                             && ($signed(c_sat) <= cfg.track_high);
                state_next = rsd_pkg::ST_TRACK;
            end
            rsd_pkg::ST_TRACK: begin
                if (hit_reg) begin
                    if (c_reg < min_reg) min_next = c_reg;
                    if (c_reg > max_reg) max_next = c_reg;
                    any_next = 1'b1;
                end
                state_next = rsd_pkg::ST_OUT;
            end
            rsd_pkg::ST_OUT: begin
                if (out_free) begin
                    mvalid_next   = 1'b1;
                    contrast_next = c_reg;
                    inval_next    = cur_reg.inval;
                    done_next     = cur_reg.last;
                    wvalid_next   = cur_reg.last && any_reg;
                    center_next   = '0;
                    width_next    = '0;
                    if (cur_reg.last && any_reg) begin
                        // arithmetic shift of the sum rounds toward minus infinity
                        center_next = sum[DW:1];
                        width_next  = (width_full > (DW + 2)'(rsd_pkg::S32_MAX))
                                      ? rsd_pkg::S32_MAX : width_full[DW-1:0];
                    end
                    if (cur_reg.last) begin
                        min_next = rsd_pkg::S32_MAX;
                        max_next = rsd_pkg::S32_MIN;
                        any_next = 1'b0;
                    end
                    state_next = rsd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= rsd_pkg::ST_IDLE;
            mvalid_reg <= 1'b0;
            min_reg    <= rsd_pkg::S32_MAX;
            max_reg    <= rsd_pkg::S32_MIN;
            any_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            any_reg    <= any_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        c_reg        <= c_next;
        hit_reg      <= hit_next;
        contrast_reg <= contrast_next;
        center_reg   <= center_next;
        width_reg    <= width_next;
        inval_reg    <= inval_next;
        wvalid_reg   <= wvalid_next;
        done_reg     <= done_next;
    end

endmodule

>>> hdl/relative_signal_difference_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relative_signal_difference_top
// Relative signal enhancement per pixel with windowed min/max tracking.
// ----------------------------------------------------------------------------
// Each request carries a signal and a baseline sample; the block returns
// (signal - baseline) / baseline, rounded to nearest and saturated, in signed
// fixed point with FRAC_BITS fraction bits. A zero baseline sets the invalid
// flag and returns zero. Results between track_low and track_high update a
// running min/max; on tlast the window center and width are reported and the
// tracker clears. A two-entry queue lets requests be taken while the back end
// works. The back end takes one pixel at a time through the bit-serial divider
// (PW = min(PIXEL_BITS, 16)), saturation, tracking and output; zero-baseline
// pixels skip the divider.
module relative_signal_difference_top #(
    parameter int PIXEL_BITS = rsd_pkg::PIXEL_BITS_DEF,
    parameter int FRAC_BITS  = rsd_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // signal_sample[15:0], baseline_sample[31:16]
    input  logic        s_axis_tlast,   // last_pixel
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // contrast, window_center, window_width
    output logic [1:0]  m_axis_tuser,   // invalid, window_valid
    output logic        m_axis_tlast    // image_done
);

    localparam logic [31:0] WIDTH_MIN = 32'(2) << FRAC_BITS;

    rsd_pkg::cfg_t  cfg_reg, cfg_next;
    rsd_pkg::item_t push_item;
    rsd_pkg::item_t pop_item;
    logic           q_push, q_full, q_pop, q_empty;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (rsd_pkg::reg_index_t'(paddr[2]))
            rsd_pkg::REG_TRACK_LOW: begin
                prdata = cfg_reg.track_low;
                if (wr_en) cfg_next.track_low = pwdata;
            end
            rsd_pkg::REG_TRACK_HIGH: begin
                prdata = cfg_reg.track_high;
                if (wr_en) cfg_next.track_high = pwdata;
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.track_low  <= rsd_pkg::TRACK_LOW_RST;
            cfg_reg.track_high <= rsd_pkg::TRACK_HIGH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rsd_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    rsd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    rsd_back #(
        .PIXEL_BITS (PIXEL_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTH
    // a zero baseline never yields a number
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("invalid result with nonzero contrast");

    // window fields only on the last pixel
    a_window_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser[1] && m_axis_tdata[95:32] == 64'd0)
        else $error("window fields set on a pixel that is not last");

    // tracked max is never below tracked min
    a_width_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[1] |->
            $signed(m_axis_tdata[95:64]) >= $signed(WIDTH_MIN))
        else $error("window width below its floor");
`endif

endmodule

>>> tb/rsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_checker
// Scoreboard for the relative signal difference block: it snoops the apb
// writes to keep its own copy of the tracking window, predicts every result
// from the accepted input requests and compares accepted results in order.
// ----------------------------------------------------------------------------
module rsd_checker
    import rsd_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // signal_sample[15:0], baseline_sample[31:16]
    input  logic        s_axis_tlast,   // last_pixel
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [95:0] m_axis_tdata,   // contrast, window_center, window_width
    input  logic [1:0]  m_axis_tuser,   // invalid, window_valid
    input  logic        m_axis_tlast,   // image_done
    output int          error_count,
    output int          pending_count
);

    typedef struct packed {
        logic [DATA_W-1:0] contrast;
        logic              invalid;
        logic              window_valid;
        logic [DATA_W-1:0] window_center;
        logic [DATA_W-1:0] window_width;
        logic              image_done;
    } pixel_result_t;

    localparam longint S32_MAX_L = 64'sd2147483647;
    localparam longint S32_MIN_L = -64'sd2147483648;

    pixel_result_t enhancement_q[$];

    logic signed [DATA_W-1:0] lo_bound;
    logic signed [DATA_W-1:0] hi_bound;
    longint                   win_min;
    longint                   win_max;
    bit                       win_any;

    function automatic longint clamp_s32(input longint v);
        if (v > S32_MAX_L) return S32_MAX_L;
        if (v < S32_MIN_L) return S32_MIN_L;
        return v;
    endfunction

    // updates the tracker as a side effect, one call per accepted request
    function automatic pixel_result_t compute_enhancement(input logic [SAMPLE_W-1:0] sig_in,
                                                          input logic [SAMPLE_W-1:0] base_in,
                                                          input logic last);
        longint        pmask;
        longint        s;
        longint        b;
        longint        mag;
        longint        q;
        longint        c;
        longint        sum;
        bit            neg;
        pixel_result_t r;
        pmask = (longint'(1) << PIXEL_BITS) - 1;
        s = longint'(sig_in) & pmask;
        b = longint'(base_in) & pmask;
        r = '0;
        r.invalid    = (b == 0);
        r.image_done = last;
        if (b != 0) begin
            neg = s < b;
            mag = neg ? (b - s) : (s - b);
            // round to nearest, ties away from zero, on the magnitude
            q = (2 * (mag << FRAC_BITS) + b) / (2 * b);
            if (q > (longint'(1) << 32)) q = longint'(1) << 32;
            c = clamp_s32(neg ? -q : q);
            r.contrast = c[DATA_W-1:0];
            if (c >= longint'(lo_bound) && c <= longint'(hi_bound)) begin
                if (c < win_min) win_min = c;
                if (c > win_max) win_max = c;
                win_any = 1'b1;
            end
        end
        if (last) begin
            if (win_any) begin
                sum = win_min + win_max;
                r.window_valid  = 1'b1;
                r.window_center = 32'(sum >>> 1);
                r.window_width  = 32'(clamp_s32((longint'(2) << FRAC_BITS) + win_max - win_min));
            end
            win_min = S32_MAX_L;
            win_max = S32_MIN_L;
            win_any = 1'b0;
        end
        return r;
    endfunction

    task automatic report_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        pixel_result_t want;
        if (!aresetn) begin
            enhancement_q.delete();
            lo_bound      = TRACK_LOW_RST;
            hi_bound      = TRACK_HIGH_RST;
            win_min       = S32_MAX_L;
            win_max       = S32_MIN_L;
            win_any       = 1'b0;
            error_count   = 0;
            pending_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[2]))
                    REG_TRACK_LOW:  lo_bound = pwdata;
                    REG_TRACK_HIGH: hi_bound = pwdata;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (enhancement_q.size() == 0) begin
                    error_count++;
                    $display("%0t: result with no request waiting, expected none actual %h",
                             $time, m_axis_tdata);
                end else begin
                    want = enhancement_q.pop_front();
                    report_field("contrast", want.contrast, m_axis_tdata[31:0]);
                    report_field("window_center", want.window_center, m_axis_tdata[63:32]);
                    report_field("window_width", want.window_width, m_axis_tdata[95:64]);
                    report_field("invalid", 32'(want.invalid), 32'(m_axis_tuser[0]));
                    report_field("window_valid", 32'(want.window_valid), 32'(m_axis_tuser[1]));
                    report_field("image_done", 32'(want.image_done), 32'(m_axis_tlast));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                enhancement_q.push_back(compute_enhancement(s_axis_tdata[15:0],
                                                            s_axis_tdata[31:16],
                                                            s_axis_tlast));
            pending_count = enhancement_q.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the relative signal difference block: directed edge pixels,
// then random images under a series of tracking windows, mostly with random
// idling on both streams. The checker beside the block scores every result.
// ----------------------------------------------------------------------------
module tb_top;
    import rsd_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_WAIT  = 100;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // signal_sample[15:0], baseline_sample[31:16]
    logic        s_axis_tlast;   // last_pixel
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;   // contrast, window_center, window_width
    logic [1:0]  m_axis_tuser;   // invalid, window_valid
    logic        m_axis_tlast;   // image_done

    int error_count;
    int pending_count;
    int idle_cycles = 0;
    bit calm = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    relative_signal_difference_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rsd_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always @(negedge aclk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 14);
    end

    // counts cycles with no request moving on any port
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_pixel(input logic [15:0] sig, input logic [15:0] base,
                              input logic last);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 14) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {base, sig};
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apb_write(input reg_index_t idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_window(input logic [31:0] lo, input logic [31:0] hi);
        wait_drained();
        apb_write(REG_TRACK_LOW, lo);
        apb_write(REG_TRACK_HIGH, hi);
    endtask

    // mostly ratios near the baseline so results land in the window
    function automatic logic [31:0] random_pixel();
        int mode;
        int b;
        int s;
        mode = $urandom_range(99);
        if (mode < 6)
            b = 0;
        else if (mode < 40)
            b = $urandom_range(1, 16);
        else
            b = $urandom_range(1, 65535);
        if (mode >= 6 && mode < 75) begin
            s = (b * $urandom_range(0, 16)) / 4 + $urandom_range(0, 2) - 1;
            if (s < 0) s = 0;
            if (s > 65535) s = 65535;
        end else begin
            s = $urandom_range(0, 65535);
        end
        return {b[15:0], s[15:0]};
    endfunction

    task automatic send_images(input int count);
        int sent;
        int len;
        logic [31:0] px;
        sent = 0;
        while (sent < count) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            for (int j = 0; j < len; j++) begin
                px = random_pixel();
                send_pixel(px[15:0], px[31:16], j == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // zero baselines, extremes and rounding ties under the reset window
        send_pixel(16'd0, 16'd0, 1'b0);
        send_pixel(16'hffff, 16'd0, 1'b0);
        send_pixel(16'd0, 16'hffff, 1'b0);
        send_pixel(16'hffff, 16'd1, 1'b0);
        send_pixel(16'hffff, 16'hffff, 1'b0);
        send_pixel(16'd8193, 16'd8192, 1'b0);
        send_pixel(16'd8191, 16'd8192, 1'b0);
        send_pixel(16'd3, 16'd1, 1'b0);
        send_pixel(16'd4, 16'd1, 1'b0);
        send_pixel(16'd5, 16'd1, 1'b1);
        send_pixel(16'd0, 16'd0, 1'b1);
        send_pixel(16'd1, 16'd0, 1'b1);
        send_pixel(16'd200, 16'd100, 1'b1);
        send_pixel(16'h5555, 16'haaaa, 1'b0);
        send_pixel(16'haaaa, 16'h5555, 1'b0);
        send_pixel(16'h8000, 16'h7fff, 1'b1);
        send_pixel(16'd7, 16'd2, 1'b0);
        send_pixel(16'd5, 16'd2, 1'b1);
        send_images(150);

        // full range, no idling on either side
        set_window(S32_MIN, S32_MAX);
        calm = 1'b1;
        send_pixel(16'd0, 16'hffff, 1'b0);
        send_pixel(16'hffff, 16'd1, 1'b1);
        send_pixel(16'd0, 16'd3, 1'b0);
        send_pixel(16'd1, 16'd3, 1'b1);
        send_images(80);
        calm = 1'b0;
        // hold off until the block has caught up
        wait_drained();
        send_images(80);

        set_window(32'sd1, 32'sd0);
        send_images(120);
        set_window(32'sd0, 32'sd0);
        send_images(120);
        set_window(-32'sd4096, 32'sd4096);
        send_images(120);
        set_window(S32_MAX, S32_MAX);
        send_images(60);
        set_window(S32_MIN, -32'sd1);
        send_images(100);
        set_window(-32'($urandom_range(0, 20000)), 32'($urandom_range(0, 20000)));
        send_images(60);
        set_window($urandom, $urandom);
        send_images(60);
        set_window(TRACK_LOW_RST, TRACK_HIGH_RST);
        send_images(60);

        wait_drained();
        repeat (TAIL_WAIT) @(negedge aclk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
hdl/rsd_pkg.sv
hdl/rsd_front.sv
hdl/rsd_fifo.sv
hdl/rsd_div.sv
hdl/rsd_back.sv
hdl/relative_signal_difference_top.sv
tb/rsd_checker.sv
tb/tb_top.sv
